/* rtl/core/cave_cellular_automaton_pass_top_assert.svh */
// Assertion macros for the cave smoothing block.
// Each macro checks a property on the rising edge of aclk, outside of reset.
`ifndef CAVE_CELLULAR_AUTOMATON_PASS_TOP_ASSERT_SVH
`define CAVE_CELLULAR_AUTOMATON_PASS_TOP_ASSERT_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define CAVE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cave smoothing assertion failed");

// Antecedent implies consequent in the next cycle.
`define CAVE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cave smoothing assertion failed");

`else

`define CAVE_ASSERT_IMP(lbl, ante, cons)
`define CAVE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/cave_ca_pkg.sv */
`timescale 1ns / 1ps

package cave_ca_pkg;

    // Cells this close to a map edge take the fixed edge rule.
    localparam int EDGE_MARGIN = 3;
    localparam int MIN_SIDE    = 8;
    localparam int RESET_SIDE  = 256;
    localparam logic [3:0] RESET_BIRTH = 4'd5;
    localparam logic [3:0] RESET_DEATH = 4'd3;

    // Result queue between the compute stage and the result channel.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BIRTH_LIMIT  = 2'd2,
        CFG_DEATH_LIMIT  = 2'd3
    } cfg_idx_t;

    // One result item as it waits in the queue.
    typedef struct packed {
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       cell_out;
        logic       last_of_run;
    } result_t;

    // A solid cell survives unless starved; an empty cell fills when crowded.
    function automatic logic apply_rule(input logic solid, input logic [3:0] count,
                                        input logic [3:0] birth, input logic [3:0] death);
        logic res;
        if (solid) begin
            res = (count < death) ? 1'b0 : 1'b1;
        end else begin
            res = (count > birth) ? 1'b1 : 1'b0;
        end
        return res;
    endfunction

endpackage

/* rtl/core/cave_ca_ram.sv */
`timescale 1ns / 1ps

module cave_ca_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; a read sees the old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/cave_cellular_automaton_pass_top.sv */
`timescale 1ns / 1ps
// Cave map smoothing, one pass of a Moore-neighborhood cellular automaton.
// Input channel s_*: one map cell per item in raster order; s_frame_start marks
// row 0 column 0. Result channel m_*: the new value of a cell with its column
// and row. A cell within three of any edge gets its result from its own item;
// an interior cell gets its result from the item one row down and one column
// right, and that interior result comes first when one item causes two.
// m_last_of_run marks the final result caused by an item.
// Configuration: cfg_we writes cfg_data to the register at cfg_index (frame
// width, frame height, birth limit, death limit); write only while idle.
// With an empty queue, a result passes the compute stage registers and then
// the result queue, from which m_valid rises. Throughput: one item per cycle
// while each item causes at most one result and m_ready stays high; the
// result port gives one result per cycle while m_ready is high. The two row
// stores share one memory port pair, read when an item is accepted and written
// back in the next cycle, with a bypass for back-to-back use of a column.
// Reset: a clearing pass over every address zeroes the row stores, with
// s_ready low. When the receiver stalls, results collect in a four-entry
// queue and s_ready drops once the queue cannot take the next item's results.
module cave_cellular_automaton_pass_top
    import cave_ca_pkg::*;
#(
    parameter int MAX_SIDE = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cell_in,
    input  logic       s_frame_start,
    // Result channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_x,
    output logic [7:0] m_cell_y,
    output logic       m_cell_out,
    output logic       m_last_of_run,
    // Configuration write port.
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

`include "cave_cellular_automaton_pass_top_assert.svh"

    localparam int CNT_W = $clog2(MAX_SIDE);
    localparam int CMP_W = (CNT_W + 1 > 10) ? CNT_W + 1 : 10;

    // Clamp a written side length into the supported range.
    function automatic logic [CMP_W-1:0] clamp_side(input logic [8:0] v);
        logic [CMP_W-1:0] ext;
        logic [CMP_W-1:0] res;
        ext = {{(CMP_W-9){1'b0}}, v};
        if (ext < CMP_W'(MIN_SIDE)) begin
            res = CMP_W'(MIN_SIDE);
        end else if (ext > CMP_W'(MAX_SIDE)) begin
            res = CMP_W'(MAX_SIDE);
        end else begin
            res = ext;
        end
        return res;
    endfunction

    // Configuration registers.
    logic [CMP_W-1:0] width_reg;
    logic [CMP_W-1:0] height_reg;
    logic [3:0]       birth_reg;
    logic [3:0]       death_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clamp_side(9'(RESET_SIDE));
            height_reg <= clamp_side(9'(RESET_SIDE));
            birth_reg  <= RESET_BIRTH;
            death_reg  <= RESET_DEATH;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= clamp_side(cfg_data);
                CFG_FRAME_HEIGHT: height_reg <= clamp_side(cfg_data);
                CFG_BIRTH_LIMIT:  birth_reg  <= cfg_data[3:0];
                CFG_DEATH_LIMIT:  death_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clearing pass over the row stores after reset.
    logic             clearing_reg;
    logic [CNT_W-1:0] clear_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end else if (clearing_reg) begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == CNT_W'(MAX_SIDE - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Position of the arriving item and its edge and interior flags.
    logic             accept;
    logic [CNT_W-1:0] col_cnt_reg;
    logic [CNT_W-1:0] row_cnt_reg;
    logic [CNT_W-1:0] x_a;
    logic [CNT_W-1:0] y_a;
    logic [CMP_W-1:0] x_ext;
    logic [CMP_W-1:0] y_ext;
    logic [CMP_W-1:0] x_p1;
    logic [CMP_W-1:0] y_p1;
    logic [CMP_W-1:0] w_m3;
    logic [CMP_W-1:0] h_m3;
    logic             edge_a;
    logic             int_a;

    assign accept = s_valid & s_ready;
    assign x_a    = s_frame_start ? '0 : col_cnt_reg;
    assign y_a    = s_frame_start ? '0 : row_cnt_reg;
    assign x_ext  = {{(CMP_W-CNT_W){1'b0}}, x_a};
    assign y_ext  = {{(CMP_W-CNT_W){1'b0}}, y_a};
    assign x_p1   = x_ext + 1'b1;
    assign y_p1   = y_ext + 1'b1;
    assign w_m3   = width_reg - CMP_W'(EDGE_MARGIN);
    assign h_m3   = height_reg - CMP_W'(EDGE_MARGIN);

    assign edge_a = (x_ext < CMP_W'(EDGE_MARGIN)) || (y_ext < CMP_W'(EDGE_MARGIN))
                 || (x_ext >= w_m3) || (y_ext >= h_m3);
    // The cell one up and one left is interior.
    assign int_a  = (x_ext >= CMP_W'(EDGE_MARGIN + 1)) && (y_ext >= CMP_W'(EDGE_MARGIN + 1))
                 && (x_ext <= w_m3) && (y_ext <= h_m3);

    // Raster counters, wrapping at the end of a row and of the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            if (x_p1 >= width_reg) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (y_p1 >= height_reg) ? '0 : y_p1[CNT_W-1:0];
            end else begin
                col_cnt_reg <= x_p1[CNT_W-1:0];
                row_cnt_reg <= y_a;
            end
        end
    end

    // Compute stage: registered item, in the cycle after acceptance.
    logic             b_valid_reg;
    logic [CNT_W-1:0] b_x_reg;
    logic [CNT_W-1:0] b_y_reg;
    logic             b_cell_reg;
    logic             b_edge_reg;
    logic             b_int_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_x_reg    <= x_a;
            b_y_reg    <= y_a;
            b_cell_reg <= s_cell_in;
            b_edge_reg <= edge_a;
            b_int_reg  <= int_a;
        end
    end

    // Row stores: bit 1 is the row one above, bit 0 the row two above.
    logic             ram_we;
    logic [CNT_W-1:0] ram_waddr;
    logic [1:0]       ram_wdata;
    logic [1:0]       ram_rdata;
    logic [1:0]       rd_pair;
    logic [1:0]       b_wdata;
    logic             fwd_hit_reg;
    logic [1:0]       fwd_data_reg;

    assign rd_pair   = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign b_wdata   = {b_cell_reg, rd_pair[1]};
    assign ram_we    = clearing_reg | b_valid_reg;
    assign ram_waddr = clearing_reg ? clear_cnt_reg : b_x_reg;
    assign ram_wdata = clearing_reg ? 2'b00 : b_wdata;

    cave_ca_ram #(
        .WIDTH (2),
        .DEPTH (MAX_SIDE)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (x_a),
        .rdata (ram_rdata)
    );

    // Bypass: a column read in the cycle it is being written back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= accept && b_valid_reg && (x_a == b_x_reg);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= b_wdata;
    end

    // 3x3 window, newest column in the low bits.
    logic [8:0] win_reg;
    logic [8:0] win_next;
    logic [3:0] nb_count;

    assign win_next = {win_reg[5:0], b_cell_reg, rd_pair[1], rd_pair[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (b_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // Count the eight neighbors around the window center.
    always_comb begin
        nb_count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                nb_count = nb_count + {3'b000, win_next[i]};
            end
        end
    end

    // Results of the compute stage.
    logic [CNT_W-1:0] tx;
    logic [CNT_W-1:0] ty;
    logic [CNT_W+7:0] tx_wide;
    logic [CNT_W+7:0] ty_wide;
    logic [CNT_W+7:0] x_wide;
    logic [CNT_W+7:0] y_wide;
    result_t          int_res;
    result_t          edge_res;
    result_t          first_res;
    logic             push_first;
    logic             push_second;
    logic [1:0]       n_push;

    assign tx      = b_x_reg - 1'b1;
    assign ty      = b_y_reg - 1'b1;
    assign tx_wide = {8'd0, tx};
    assign ty_wide = {8'd0, ty};
    assign x_wide  = {8'd0, b_x_reg};
    assign y_wide  = {8'd0, b_y_reg};

    always_comb begin
        int_res.cell_x       = tx_wide[7:0];
        int_res.cell_y       = ty_wide[7:0];
        int_res.cell_out     = apply_rule(win_next[4], nb_count, birth_reg, death_reg);
        int_res.last_of_run  = !b_edge_reg;
        edge_res.cell_x      = x_wide[7:0];
        edge_res.cell_y      = y_wide[7:0];
        edge_res.cell_out    = apply_rule(b_cell_reg, 4'd1, birth_reg, death_reg);
        edge_res.last_of_run = 1'b1;
    end

    assign first_res   = b_int_reg ? int_res : edge_res;
    assign push_first  = b_valid_reg & (b_int_reg | b_edge_reg);
    assign push_second = b_valid_reg & b_int_reg & b_edge_reg;
    assign n_push      = {1'b0, push_first} + {1'b0, push_second};

    // Result queue.
    result_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] q_count_reg;
    logic              pop;

    assign m_valid = (q_count_reg != '0);
    assign pop     = m_valid & m_ready;

    always_ff @(posedge aclk) begin
        if (push_first) begin
            q_reg[wr_ptr_reg] <= first_res;
        end
        if (push_second) begin
            q_reg[wr_ptr_reg + 1'b1] <= edge_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_reg + QPTR_W'(n_push);
            rd_ptr_reg  <= rd_ptr_reg + QPTR_W'(pop);
            q_count_reg <= q_count_reg + QCNT_W'(n_push) - QCNT_W'(pop);
        end
    end

    // Take an item only if the queue holds both its results and those in flight.
    assign s_ready = !clearing_reg
                  && (({1'b0, q_count_reg} + 4'(n_push)) <= 4'(QDEPTH - 2));

    assign m_cell_x      = q_reg[rd_ptr_reg].cell_x;
    assign m_cell_y      = q_reg[rd_ptr_reg].cell_y;
    assign m_cell_out    = q_reg[rd_ptr_reg].cell_out;
    assign m_last_of_run = q_reg[rd_ptr_reg].last_of_run;

    // No item may enter while the row stores are being cleared.
    `CAVE_ASSERT_IMP(a_no_accept_in_clear, clearing_reg, !s_ready)
    // The queue never receives more results than it has room for.
    `CAVE_ASSERT_IMP(a_queue_room, b_valid_reg,
                     ({1'b0, q_count_reg} + 4'(n_push)) <= 4'(QDEPTH))
    // A bypass is only armed for an item that is now in the compute stage.
    `CAVE_ASSERT_IMP(a_fwd_with_item, fwd_hit_reg, b_valid_reg)
    // An accepted item reaches the compute stage in the next cycle.
    `CAVE_ASSERT_NXT(a_item_advances, accept, b_valid_reg && !clearing_reg)

endmodule

/* tb/sv/tb_cave_cellular_automaton_pass_top.sv */
`timescale 1ns / 1ps

module tb_cave_cellular_automaton_pass_top;
    import cave_ca_pkg::*;

    localparam int MAX_SIDE     = 256;
    localparam int RUN_CELLS    = 1450;
    localparam int SETTLE_TICKS = 8;
    localparam int LONG_HOLD    = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 100;

    // Directed cell patterns, bit 0 is sent first.
    localparam logic [12:0] RESTART_CELLS = 13'b1_0100_1110_1101;
    localparam logic [11:0] SHRINK_CELLS  = 12'b0110_1011_0010;

    // One map cell as the input channel carries it.
    typedef struct packed {
        logic cell_val;
        logic start;
    } cell_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cell_in = 1'b0;
    logic       s_frame_start = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_cell_x;
    logic [7:0] m_cell_y;
    logic       m_cell_out;
    logic       m_last_of_run;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [8:0] cfg_data = '0;

    // Stimulus and scoreboard bookkeeping.
    cell_item_t pending_cells[$];
    result_t    expected_results[$];
    int         cells_queued = 0;
    int         cells_accepted = 0;
    int         mismatch_count = 0;
    int         stall_cycles = 0;
    int         hold_asked = 0;
    int         hold_served = 0;
    int         tx_wait = 0;
    int         rx_wait = 0;
    bit         tx_steady = 1'b0;
    bit         rx_steady = 1'b0;

    // Shadow of the block: configuration, line buffers, window and raster position.
    logic [8:0]          shadow_width = 9'(RESET_SIDE);
    logic [8:0]          shadow_height = 9'(RESET_SIDE);
    logic [3:0]          birth_at = RESET_BIRTH;
    logic [3:0]          death_at = RESET_DEATH;
    logic [MAX_SIDE-1:0] older_row = '0;
    logic [MAX_SIDE-1:0] newer_row = '0;
    logic [8:0]          window = '0;
    logic [7:0]          map_col = '0;
    logic [7:0]          map_row = '0;

    cave_cellular_automaton_pass_top #(
        .MAX_SIDE(MAX_SIDE)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_in    (s_cell_in),
        .s_frame_start(s_frame_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_x     (m_cell_x),
        .m_cell_y     (m_cell_y),
        .m_cell_out   (m_cell_out),
        .m_last_of_run(m_last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Size registers are used clamped to the supported range.
    function automatic int side_used(input logic [8:0] value);
        if (value < MIN_SIDE) begin
            return MIN_SIDE;
        end
        if (value > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(value);
    endfunction

    // Survival and birth rule for one cell given its solid neighbor count.
    function automatic logic smooth_rule(input logic solid, input int neighbors);
        if (solid) begin
            return (neighbors < int'(death_at)) ? 1'b0 : 1'b1;
        end
        return (neighbors > int'(birth_at)) ? 1'b1 : 1'b0;
    endfunction

    // Works out the results that one accepted cell causes and queues them.
    task automatic predict_cell(input logic cell_val, input logic start);
        int      w, h, x, y, tx, ty;
        logic    up2, up1;
        bit      is_inner, is_edge;
        result_t res;
        if (start) begin
            map_col = '0;
            map_row = '0;
        end
        w = side_used(shadow_width);
        h = side_used(shadow_height);
        x = int'(map_col);
        y = int'(map_row);

        // Shift the column through the line buffers and into the window.
        up2 = older_row[x];
        up1 = newer_row[x];
        older_row[x] = up1;
        newer_row[x] = cell_val;
        window = {window[5:0], cell_val, up1, up2};

        tx = x - 1;
        ty = y - 1;
        is_inner = tx >= EDGE_MARGIN && ty >= EDGE_MARGIN &&
                   tx <= w - 1 - EDGE_MARGIN && ty <= h - 1 - EDGE_MARGIN;
        is_edge = x < EDGE_MARGIN || y < EDGE_MARGIN ||
                  x > w - 1 - EDGE_MARGIN || y > h - 1 - EDGE_MARGIN;

        // The delayed interior cell is centered in the window, one up and one left.
        if (is_inner) begin
            res.cell_x = tx[7:0];
            res.cell_y = ty[7:0];
            res.cell_out = smooth_rule(window[4], $countones(window & 9'h1EF));
            res.last_of_run = !is_edge;
            expected_results.insert(expected_results.size(), res);
        end
        // Cells near a border behave as if they had exactly one solid neighbor.
        if (is_edge) begin
            res.cell_x = map_col;
            res.cell_y = map_row;
            res.cell_out = smooth_rule(cell_val, 1);
            res.last_of_run = 1'b1;
            expected_results.insert(expected_results.size(), res);
        end

        // Raster advance, wrapping to the origin after the last row.
        if (x + 1 >= w) begin
            map_col = '0;
            map_row = (y + 1 >= h) ? 8'd0 : 8'(y + 1);
        end else begin
            map_col = 8'(x + 1);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Compares one accepted result against the oldest prediction.
    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result for cell (%0d,%0d)",
                                      m_cell_x, m_cell_y));
        end else begin
            want = expected_results.pop_front();
            if (m_cell_x !== want.cell_x) begin
                report_mismatch($sformatf("cell_x %0d, predicted %0d", m_cell_x, want.cell_x));
            end
            if (m_cell_y !== want.cell_y) begin
                report_mismatch($sformatf("cell_y %0d, predicted %0d", m_cell_y, want.cell_y));
            end
            if (m_cell_out !== want.cell_out) begin
                report_mismatch($sformatf("cell_out %b at (%0d,%0d), predicted %b",
                                          m_cell_out, want.cell_x, want.cell_y,
                                          want.cell_out));
            end
            if (m_last_of_run !== want.last_of_run) begin
                report_mismatch($sformatf("last_of_run %b at (%0d,%0d), predicted %b",
                                          m_last_of_run, want.cell_x, want.cell_y,
                                          want.last_of_run));
            end
        end
    endtask

    // Monitor: predicts on every accepted cell and checks every accepted result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_cell(s_cell_in, s_frame_start);
                cells_accepted++;
            end
            if (m_valid && m_ready) begin
                check_result();
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Driver: presents queued cells, with a random gap after each item.
    always @(posedge aclk) begin : cell_driver
        cell_item_t nxt;
        int         gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (tx_wait != 0) begin
                s_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (pending_cells.size() != 0) begin
                nxt = pending_cells.pop_front();
                gap = tx_steady ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 29) == 0) begin
                    tx_steady <= !tx_steady;
                end
                s_valid <= 1'b1;
                s_cell_in <= nxt.cell_val;
                s_frame_start <= nxt.start;
                tx_wait <= gap;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls per item, plus a long hold-off on request.
    always @(posedge aclk) begin : result_sink
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            m_ready <= 1'b0;
            rx_wait <= LONG_HOLD;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else if (m_valid && m_ready) begin
            gap = rx_steady ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 29) == 0) begin
                rx_steady <= !rx_steady;
            end
            rx_wait <= gap;
            m_ready <= (gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic put_reg(input cfg_idx_t idx, input logic [8:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
    endtask

    // Writes all four registers back to back; only called while the block is idle.
    task automatic load_config(input logic [8:0] width, input logic [8:0] height,
                               input logic [3:0] birth, input logic [3:0] death);
        put_reg(CFG_FRAME_WIDTH, width);
        put_reg(CFG_FRAME_HEIGHT, height);
        put_reg(CFG_BIRTH_LIMIT, 9'(birth));
        put_reg(CFG_DEATH_LIMIT, 9'(death));
        cfg_we <= 1'b0;
        shadow_width = width;
        shadow_height = height;
        birth_at = birth;
        death_at = death;
    endtask

    task automatic queue_cell(input logic cell_val, input logic start);
        cell_item_t item;
        item.cell_val = cell_val;
        item.start = start;
        pending_cells.insert(pending_cells.size(), item);
        cells_queued++;
    endtask

    // Waits until every cell is taken and every result is back, then lets
    // cells that cause no result drain out of the pipeline.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (cells_accepted != cells_queued || expected_results.size() != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    function automatic logic rnd_cell(input int density);
        return ($urandom_range(0, 99) < density) ? 1'b1 : 1'b0;
    endfunction

    function automatic logic [3:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 4'd0;
            1: return 4'd8;
            2: return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(0, 8));
        endcase
    endfunction

    // One random pass: new settings, then whole frames with random content,
    // or a cut-short, restarted or noisy sequence.
    task automatic random_pass(input bit hold_rx, input bit go_wide);
        int         w, h, kind, density, n, cut;
        bit         lead;
        logic [8:0] wv, hv;
        case ($urandom_range(0, 19))
            0: wv = 9'($urandom_range(0, 7));
            1: wv = 9'($urandom_range(257, 511));
            2: wv = 9'd8;
            default: wv = 9'($urandom_range(8, 14));
        endcase
        case ($urandom_range(0, 19))
            0: hv = 9'($urandom_range(0, 7));
            1: hv = 9'($urandom_range(257, 511));
            2: hv = 9'd8;
            default: hv = 9'($urandom_range(8, 10));
        endcase
        if (go_wide) begin
            wv = 9'd256;
        end
        load_config(wv, hv, pick_limit(), pick_limit());
        w = side_used(wv);
        h = side_used(hv);
        density = 25 * $urandom_range(0, 4);
        // Without a leading frame start the counters carry on from the last pass.
        lead = ($urandom_range(0, 3) != 0);
        kind = hold_rx ? $urandom_range(0, 5) : $urandom_range(0, 9);
        if (w * h > 400) begin
            kind = 7;
        end

        case (kind)
            0: begin
                // Two frames back to back: the second begins on the counter wrap.
                for (int i = 0; i < 2 * w * h; i++) begin
                    queue_cell(rnd_cell(density), lead && i == 0);
                end
            end
            6: begin
                // Frame start in the middle of a frame, then a whole frame.
                cut = $urandom_range(5, w * h - 1);
                for (int i = 0; i < cut; i++) begin
                    queue_cell(rnd_cell(density), lead && i == 0);
                end
                for (int i = 0; i < w * h; i++) begin
                    queue_cell(rnd_cell(density), i == 0);
                end
            end
            7: begin
                // Frame left unfinished, so the next pass may resume past the size.
                n = (w * h > 400) ? $urandom_range(40, 300) : $urandom_range(1, w * h - 1);
                for (int i = 0; i < n; i++) begin
                    queue_cell(rnd_cell(density), lead && i == 0);
                end
            end
            8, 9: begin
                // Noise: frame starts at random places.
                n = $urandom_range(40, 80);
                for (int i = 0; i < n; i++) begin
                    queue_cell(rnd_cell(density), $urandom_range(0, 5) == 0);
                end
            end
            default: begin
                for (int i = 0; i < w * h; i++) begin
                    queue_cell(rnd_cell(density), lead && i == 0);
                end
            end
        endcase

        if (hold_rx) begin
            hold_asked <= hold_asked + 1;
        end
        wait_drained();
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        int pass_no;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // The line buffers are cleared after reset before cells are taken.
        do begin
            @(posedge aclk);
        end while (!s_ready);

        // Wide width, height clamped down from the top, limits that kill every cell;
        // a frame start arrives three cells into the frame.
        load_config(9'd20, 9'd511, 4'd15, 4'd9);
        for (int i = 0; i < 13; i++) begin
            queue_cell(RESTART_CELLS[i], i == 0 || i == 3);
        end
        wait_drained();

        // Width shrinks below the current column; sizes clamp up, zero limits.
        load_config(9'd5, 9'd0, 4'd0, 4'd0);
        for (int i = 0; i < 12; i++) begin
            queue_cell(SHRINK_CELLS[i], 1'b0);
        end
        wait_drained();

        pass_no = 0;
        while (cells_queued < RUN_CELLS) begin
            random_pass(pass_no == 1 || pass_no == 7, pass_no == 4);
            pass_no++;
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/cave_ca_pkg.sv
rtl/core/cave_ca_ram.sv
rtl/core/cave_cellular_automaton_pass_top.sv
tb/sv/tb_cave_cellular_automaton_pass_top.sv
